### design/lksc_pkg.sv
package lksc_pkg;

    localparam int NUM_SLOTS_DEF = 4;
    localparam int MAX_LEN_DEF   = 4800;

    localparam int KEY_W  = 64;
    localparam int LEN_W  = 16;
    localparam int TICK_W = 32;
    localparam int SLOT_W = 2;
    localparam int STAT_W = 3;

    typedef enum logic [STAT_W-1:0] {
        ST_HIT      = 3'd0,
        ST_MISS     = 3'd1,
        ST_INSERTED = 3'd2,
        ST_PRESENT  = 3'd3,
        ST_REJECTED = 3'd4
    } status_t;

    typedef enum logic {
        REQ_GET = 1'b0,
        REQ_PUT = 1'b1
    } req_kind_t;

    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] length;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  stored_length;
    } rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT,
        S_SEND
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_last;
    } dp_sts_t;

endpackage

### design/lru_keyed_slot_cache_unit.sv
// Tag store of a small fully associative cache with least-recently-used
// replacement. Each req word is a get or put of a nonzero 64-bit key; one rsp
// word answers it with a status, the slot touched and, on a get hit, the stored
// length. Requests are handled one at a time: a word is accepted, the tag array
// is scanned one slot per cycle, the update is applied in the commit state, and
// the rsp word is then held until taken. A new req word is accepted in the same
// cycle the pending rsp word is taken.
module lru_keyed_slot_cache_unit #(
    parameter int NUM_SLOTS = lksc_pkg::NUM_SLOTS_DEF,
    parameter int MAX_LEN   = lksc_pkg::MAX_LEN_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  lksc_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output lksc_pkg::rsp_t rsp
);

    lksc_pkg::dp_cmd_t cmd;
    lksc_pkg::dp_sts_t sts;

    lksc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    lksc_dp #(
        .NUM_SLOTS (NUM_SLOTS),
        .MAX_LEN   (MAX_LEN)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .sts   (sts)
    );

endmodule

### design/lksc_ctrl.sv
module lksc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output lksc_pkg::dp_cmd_t  cmd,
    input  lksc_pkg::dp_sts_t  sts
);

    lksc_pkg::ctrl_state_t state_reg;
    lksc_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lksc_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_stall  = 1'b1;
        rsp_valid  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            lksc_pkg::S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = lksc_pkg::S_SCAN;
                end
            end
            lksc_pkg::S_SCAN:
            begin
                cmd.step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = lksc_pkg::S_COMMIT;
                end
            end
            lksc_pkg::S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = lksc_pkg::S_SEND;
            end
            lksc_pkg::S_SEND:
            begin
                rsp_valid = 1'b1;
                req_stall = rsp_stall;
                if (!rsp_stall)
                begin
                    // take the next word as the current one leaves
                    if (req_valid)
                    begin
                        cmd.load   = 1'b1;
                        state_next = lksc_pkg::S_SCAN;
                    end
                    else
                    begin
                        state_next = lksc_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = lksc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### design/lksc_dp.sv
module lksc_dp #(
    parameter int NUM_SLOTS = lksc_pkg::NUM_SLOTS_DEF,
    parameter int MAX_LEN   = lksc_pkg::MAX_LEN_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lksc_pkg::req_t     req,
    output lksc_pkg::rsp_t     rsp,
    input  lksc_pkg::dp_cmd_t  cmd,
    output lksc_pkg::dp_sts_t  sts
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    logic [lksc_pkg::KEY_W-1:0]  slot_key_reg    [NUM_SLOTS];
    logic [lksc_pkg::LEN_W-1:0]  slot_length_reg [NUM_SLOTS];
    logic [lksc_pkg::TICK_W-1:0] slot_tick_reg   [NUM_SLOTS];
    logic [lksc_pkg::TICK_W-1:0] use_counter_reg;
    logic [lksc_pkg::TICK_W-1:0] use_counter_next;

    lksc_pkg::req_t              cur_req_reg;
    lksc_pkg::rsp_t              rsp_reg;
    lksc_pkg::rsp_t              rsp_next;

    logic [IDX_W-1:0]            idx_reg;
    logic                        hit_found_reg;
    logic [IDX_W-1:0]            hit_idx_reg;
    logic [lksc_pkg::LEN_W-1:0]  hit_len_reg;
    logic                        empty_found_reg;
    logic [IDX_W-1:0]            empty_idx_reg;
    logic                        min_found_reg;
    logic [IDX_W-1:0]            min_idx_reg;
    logic [lksc_pkg::TICK_W-1:0] min_tick_reg;

    logic [lksc_pkg::KEY_W-1:0]  cur_key;
    logic [lksc_pkg::TICK_W-1:0] cur_tick;
    logic                        cur_empty;
    logic                        key_match;

    logic                        rejected;
    logic                        is_put;
    logic                        do_stamp;
    logic                        do_fill;
    logic [IDX_W-1:0]            victim;
    logic [IDX_W-1:0]            wr_idx;

    assign cur_key   = slot_key_reg[idx_reg];
    assign cur_tick  = slot_tick_reg[idx_reg];
    assign cur_empty = (cur_key == '0);
    assign key_match = !cur_empty && (cur_key == cur_req_reg.key);

    assign sts.scan_last = (idx_reg == LAST_IDX);

    // scan one slot per cycle: first hit, last empty slot, oldest tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg         <= '0;
            hit_found_reg   <= 1'b0;
            empty_found_reg <= 1'b0;
            min_found_reg   <= 1'b0;
        end
        else if (cmd.load)
        begin
            idx_reg         <= '0;
            hit_found_reg   <= 1'b0;
            empty_found_reg <= 1'b0;
            min_found_reg   <= 1'b0;
        end
        else if (cmd.step)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
            if (key_match && !hit_found_reg)
            begin
                hit_found_reg <= 1'b1;
            end
            if (cur_empty)
            begin
                empty_found_reg <= 1'b1;
            end
            else if (cur_tick < min_tick_reg)
            begin
                min_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_req_reg  <= req;
            min_tick_reg <= '1;
        end
        else if (cmd.step)
        begin
            if (key_match && !hit_found_reg)
            begin
                hit_idx_reg <= idx_reg;
                hit_len_reg <= slot_length_reg[idx_reg];
            end
            if (cur_empty)
            begin
                empty_idx_reg <= idx_reg;
            end
            else if (cur_tick < min_tick_reg)
            begin
                min_tick_reg <= cur_tick;
                min_idx_reg  <= idx_reg;
            end
        end
    end

    always_comb
    begin
        is_put   = (cur_req_reg.req_type == lksc_pkg::REQ_PUT);
        rejected = (cur_req_reg.key == '0) ||
                   (is_put && ((cur_req_reg.length == '0) ||
                               (cur_req_reg.length > lksc_pkg::LEN_W'(MAX_LEN))));

        if (empty_found_reg)
        begin
            victim = empty_idx_reg;
        end
        else if (min_found_reg)
        begin
            victim = min_idx_reg;
        end
        else
        begin
            victim = '0;
        end

        do_stamp = !rejected && (hit_found_reg || is_put);
        do_fill  = !rejected && is_put && !hit_found_reg;
        wr_idx   = hit_found_reg ? hit_idx_reg : victim;
        use_counter_next = use_counter_reg + lksc_pkg::TICK_W'(1);

        rsp_next = '0;
        if (rejected)
        begin
            rsp_next.status = lksc_pkg::ST_REJECTED;
        end
        else if (!is_put)
        begin
            if (hit_found_reg)
            begin
                rsp_next.status        = lksc_pkg::ST_HIT;
                rsp_next.slot          = lksc_pkg::SLOT_W'(hit_idx_reg);
                rsp_next.stored_length = hit_len_reg;
            end
            else
            begin
                rsp_next.status = lksc_pkg::ST_MISS;
            end
        end
        else if (hit_found_reg)
        begin
            rsp_next.status = lksc_pkg::ST_PRESENT;
            rsp_next.slot   = lksc_pkg::SLOT_W'(hit_idx_reg);
        end
        else
        begin
            rsp_next.status = lksc_pkg::ST_INSERTED;
            rsp_next.slot   = lksc_pkg::SLOT_W'(victim);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_counter_reg <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_key_reg[i]    <= '0;
                slot_length_reg[i] <= '0;
                slot_tick_reg[i]   <= '0;
            end
        end
        else if (cmd.commit)
        begin
            if (do_stamp)
            begin
                use_counter_reg       <= use_counter_next;
                slot_tick_reg[wr_idx] <= use_counter_next;
            end
            if (do_fill)
            begin
                slot_key_reg[wr_idx]    <= cur_req_reg.key;
                slot_length_reg[wr_idx] <= cur_req_reg.length;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

### sim/lru_keyed_slot_cache_unit_tb.sv
module lru_keyed_slot_cache_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS   = lksc_pkg::NUM_SLOTS_DEF;
    localparam int LEN_MAX = lksc_pkg::MAX_LEN_DEF;
    localparam int RANDOM_WORDS = 950;
    localparam int POOL_SIZE    = 6;
    localparam int HOLD_AT      = 2500;
    localparam int HOLD_CYCLES  = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    lksc_pkg::req_t req_word = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    lksc_pkg::rsp_t rsp_word;

    lksc_pkg::req_t pending_words[$];
    lksc_pkg::rsp_t answers_due[$];
    int   total_words = 0;
    int   accepted_count = 0;
    int   mismatch_count = 0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   stall_cycle = 0;
    int   hold_left = 0;

    // Tag store copy used for prediction
    logic [lksc_pkg::KEY_W-1:0]  cache_key[SLOTS];
    logic [lksc_pkg::LEN_W-1:0]  cache_len[SLOTS];
    logic [lksc_pkg::TICK_W-1:0] cache_tick[SLOTS];
    logic [lksc_pkg::TICK_W-1:0] stamp_count;

    logic [lksc_pkg::KEY_W-1:0] key_pool[POOL_SIZE];

    lru_keyed_slot_cache_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp_word)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #5_000_000;
        $display("lru_keyed_slot_cache_unit_tb: done, errors");
        $finish;
    end

    function automatic void stamp_slot(int s);
        stamp_count = stamp_count + 1'b1;
        cache_tick[s] = stamp_count;
    endfunction

    function automatic int find_slot(logic [lksc_pkg::KEY_W-1:0] k);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (cache_key[i] != '0 && cache_key[i] == k)
                return i;
        end
        return -1;
    endfunction

    // Highest empty slot wins; else oldest tick, lowest index on ties
    function automatic int choose_victim();
        int                          empty_slot;
        int                          oldest;
        logic [lksc_pkg::TICK_W-1:0] oldest_tick;
        empty_slot = -1;
        oldest = 0;
        oldest_tick = '1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (cache_key[i] == '0)
                empty_slot = i;
            else if (cache_tick[i] < oldest_tick)
            begin
                oldest_tick = cache_tick[i];
                oldest = i;
            end
        end
        return (empty_slot >= 0) ? empty_slot : oldest;
    endfunction

    function automatic lksc_pkg::rsp_t tag_store_answer(lksc_pkg::req_t w);
        lksc_pkg::rsp_t ans;
        int             hit_slot;
        int             victim;
        ans = '0;
        if (w.key == '0)
            ans.status = lksc_pkg::ST_REJECTED;
        else if (w.req_type == lksc_pkg::REQ_GET)
        begin
            hit_slot = find_slot(w.key);
            if (hit_slot >= 0)
            begin
                stamp_slot(hit_slot);
                ans.status = lksc_pkg::ST_HIT;
                ans.slot = lksc_pkg::SLOT_W'(hit_slot);
                ans.stored_length = cache_len[hit_slot];
            end
            else
                ans.status = lksc_pkg::ST_MISS;
        end
        else if (w.length == '0 || int'(w.length) > LEN_MAX)
            ans.status = lksc_pkg::ST_REJECTED;
        else
        begin
            hit_slot = find_slot(w.key);
            if (hit_slot >= 0)
            begin
                stamp_slot(hit_slot);
                ans.status = lksc_pkg::ST_PRESENT;
                ans.slot = lksc_pkg::SLOT_W'(hit_slot);
            end
            else
            begin
                victim = choose_victim();
                cache_key[victim] = w.key;
                cache_len[victim] = w.length;
                stamp_slot(victim);
                ans.status = lksc_pkg::ST_INSERTED;
                ans.slot = lksc_pkg::SLOT_W'(victim);
            end
        end
        return ans;
    endfunction

    function automatic void queue_word(lksc_pkg::req_kind_t kind,
                                       logic [lksc_pkg::KEY_W-1:0] k,
                                       logic [lksc_pkg::LEN_W-1:0] len);
        lksc_pkg::req_t w;
        w.req_type = kind;
        w.key = k;
        w.length = len;
        pending_words.push_back(w);
        total_words++;
    endfunction

    function automatic logic [lksc_pkg::KEY_W-1:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    initial
    begin
        lksc_pkg::req_kind_t        kind;
        logic [lksc_pkg::KEY_W-1:0] k;
        logic [lksc_pkg::LEN_W-1:0] len;
        int                         pick;

        for (int i = 0; i < SLOTS; i++)
        begin
            cache_key[i] = '0;
            cache_len[i] = '0;
            cache_tick[i] = '0;
        end
        stamp_count = '0;

        queue_word(lksc_pkg::REQ_GET, 64'd1, 16'd0);
        queue_word(lksc_pkg::REQ_GET, 64'd0, 16'd9);
        queue_word(lksc_pkg::REQ_PUT, 64'd0, 16'd10);
        queue_word(lksc_pkg::REQ_PUT, 64'hA5A5_0000_1234_5678, 16'd0);
        queue_word(lksc_pkg::REQ_PUT, 64'hA5A5_0000_1234_5678, 16'd4801);
        queue_word(lksc_pkg::REQ_PUT, 64'hA5A5_0000_1234_5678, 16'hFFFF);
        queue_word(lksc_pkg::REQ_PUT, 64'hA5A5_0000_1234_5678, 16'd4800);
        queue_word(lksc_pkg::REQ_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 16'd1);
        queue_word(lksc_pkg::REQ_PUT, 64'h8000_0000_0000_0000, 16'd100);
        queue_word(lksc_pkg::REQ_PUT, 64'd1, 16'd77);
        queue_word(lksc_pkg::REQ_GET, 64'hA5A5_0000_1234_5678, 16'd0);
        queue_word(lksc_pkg::REQ_GET, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
        queue_word(lksc_pkg::REQ_PUT, 64'd1, 16'd5);
        // cache full: next fill evicts the oldest entry
        queue_word(lksc_pkg::REQ_PUT, 64'd2, 16'd300);
        queue_word(lksc_pkg::REQ_GET, 64'h8000_0000_0000_0000, 16'd0);
        queue_word(lksc_pkg::REQ_GET, 64'd2, 16'h1234);
        queue_word(lksc_pkg::REQ_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 16'd4800);
        queue_word(lksc_pkg::REQ_PUT, 64'd3, 16'd4799);
        queue_word(lksc_pkg::REQ_PUT, 64'h5555_5555_5555_5555, 16'd2);
        queue_word(lksc_pkg::REQ_PUT, 64'hAAAA_AAAA_AAAA_AAAA, 16'h0AAA);
        queue_word(lksc_pkg::REQ_GET, 64'h5555_5555_5555_5555, 16'd0);
        queue_word(lksc_pkg::REQ_GET, 64'hAAAA_AAAA_AAAA_AAAA, 16'd0);
        queue_word(lksc_pkg::REQ_PUT, 64'h0000_0000_0000_0001, 16'hFFFF);

        for (int i = 0; i < POOL_SIZE; i++)
        begin
            key_pool[i] = rand_key();
            if (key_pool[i] == '0)
                key_pool[i] = 64'd7;
        end

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            // refresh a pool entry now and then so evicted keys come and go
            if ($urandom_range(0, 39) == 0)
                key_pool[$urandom_range(0, POOL_SIZE - 1)] = rand_key() | 64'd1;
            pick = $urandom_range(0, 99);
            if (pick < 3)
                k = '0;
            else if (pick < 80)
                k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                k = rand_key();
            kind = ($urandom_range(0, 1) == 0) ? lksc_pkg::REQ_GET : lksc_pkg::REQ_PUT;
            if (kind == lksc_pkg::REQ_PUT && $urandom_range(0, 99) < 85)
                len = lksc_pkg::LEN_W'($urandom_range(1, LEN_MAX));
            else
                len = lksc_pkg::LEN_W'($urandom());
            queue_word(kind, k, len);
        end

        wait (rst_n);
        while (accepted_count != total_words)
            @(posedge clk);
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("lru_keyed_slot_cache_unit_tb: done, clean");
        else
            $display("lru_keyed_slot_cache_unit_tb: done, errors");
        $finish;
    end

    // Sender: bursts of words with random gaps; hold the word while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_word <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                answers_due.push_back(tag_store_answer(req_word));
                accepted_count++;
            end
            if (!req_valid || !req_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    req_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    req_word <= pending_words.pop_front();
                    req_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        if ($urandom_range(0, 7) == 0)
                        begin
                            burst_left <= $urandom_range(30, 60);
                            gap_left <= 0;
                        end
                        else
                        begin
                            burst_left <= $urandom_range(1, 12);
                            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                        end
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern; one long hold-off to back the block up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            stall_cycle <= 0;
            hold_left <= 0;
        end
        else
        begin
            stall_cycle <= stall_cycle + 1;
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                rsp_stall <= 1'b1;
            end
            else if (stall_cycle == HOLD_AT)
            begin
                hold_left <= HOLD_CYCLES;
                rsp_stall <= 1'b1;
            end
            else
            begin
                case (stall_cycle[10:9])
                    2'd0: rsp_stall <= 1'b0;
                    2'd1: rsp_stall <= ($urandom_range(0, 99) < 50);
                    2'd2: rsp_stall <= ($urandom_range(0, 99) < 10);
                    default: rsp_stall <= ($urandom_range(0, 99) < 75);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        lksc_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (answers_due.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("%0t: unexpected rsp word status=%0d slot=%0d len=%0d",
                             $realtime, rsp_word.status, rsp_word.slot,
                             rsp_word.stored_length);
                mismatch_count++;
            end
            else
            begin
                want = answers_due.pop_front();
                if (rsp_word.status !== want.status || rsp_word.slot !== want.slot ||
                    rsp_word.stored_length !== want.stored_length)
                begin
                    if (mismatch_count < 10)
                        $display({"%0t: rsp mismatch: want status=%0d slot=%0d len=%0d,",
                                  " got status=%0d slot=%0d len=%0d"},
                                 $realtime, want.status, want.slot, want.stored_length,
                                 rsp_word.status, rsp_word.slot, rsp_word.stored_length);
                    mismatch_count++;
                end
            end
        end
    end

endmodule
